>>> rtl/text_terminal_put_char_top_defines.svh
// Assertion macros shared by the text console RTL.
`ifndef TEXT_TERMINAL_PUT_CHAR_TOP_DEFINES_SVH
`define TEXT_TERMINAL_PUT_CHAR_TOP_DEFINES_SVH

// Clocked assertion on clk_i, disabled while rst_ni is low.
`define TTPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication form: antecedent on one edge, consequent on the next.
`define TTPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/ttpc_pkg.sv
// Shared widths and codes of the text console.
`timescale 1ns / 1ps
package ttpc_pkg;

  localparam int CharWidth = 8;
  localparam int AttrWidth = 8;
  localparam int AddrWidth = 11;
  localparam int CellWidth = 16;

  localparam logic ActPut  = 1'b0;
  localparam logic ActRead = 1'b1;

  localparam logic [CharWidth-1:0] NewlineCode = 8'h0A;
  localparam logic [CellWidth-1:0] BlankCell   = 16'h0F20;
  localparam logic [AttrWidth-1:0] AttrReset   = 8'h0F;

endpackage

>>> rtl/ttpc_if.sv
// Valid/ready channel interfaces for console items and results.
`timescale 1ns / 1ps
interface ttpc_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 action;
  logic [ttpc_pkg::CharWidth-1:0]       char_code;
  logic [ttpc_pkg::AddrWidth-1:0]       cell_address;

  modport source (output valid, action, char_code, cell_address, input ready);
  modport sink   (input valid, action, char_code, cell_address, output ready);
endinterface

interface ttpc_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [ttpc_pkg::CellWidth-1:0]       cell_value;
  logic [ttpc_pkg::AddrWidth-1:0]       cursor_position;
  logic                                 scrolled;

  modport source (output valid, cell_value, cursor_position, scrolled, input ready);
  modport sink   (input valid, cell_value, cursor_position, scrolled, output ready);
endinterface

>>> rtl/text_terminal_put_char_top.sv
// Top level of the character-cell text console with cursor and scroll.
`timescale 1ns / 1ps
`include "text_terminal_put_char_top_defines.svh"

// Text console of ROWS x COLUMNS 16-bit cells (attribute high byte, character
// low byte) held in one single-port-write RAM, plus a cursor. Each input
// transaction yields exactly one result transaction. After reset the block
// runs a clearing pass that writes a blank white-on-black space into every
// cell, one cell per cycle, and raises ready only when that pass is done;
// attribute writes are taken at any time. A put that does not scroll is
// accepted, then loaded into the output register; a read is accepted, then
// waits for the registered RAM read data, then is loaded. A put that moves
// past the last row copies the screen up one row through the one RAM write
// port, one cell per cycle, then blanks the bottom row before it is loaded.
// The finished result sits in an output register, so a new transaction can
// be accepted while the previous result waits on a stalled sink.
module text_terminal_put_char_top #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ttpc_pkg::AttrWidth-1:0]   cfg_wdata_i,
  ttpc_in_if.sink                          in_i,
  ttpc_out_if.source                       out_o
);

  localparam int CellCount = ROWS * COLUMNS;
  localparam int CopyCount = (ROWS - 1) * COLUMNS;
  localparam int Aw        = $clog2(CellCount);
  localparam int Cw        = $clog2(CellCount + 1);
  localparam int Clw       = $clog2(COLUMNS);
  localparam int Rw        = $clog2(ROWS);

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StReadWait,
    StScroll,
    StEmit
  } state_e;

  state_e state_q;

  logic [ttpc_pkg::AttrWidth-1:0] attr_q;
  logic [Clw-1:0]                 col_q, col_d;
  logic [Rw-1:0]                  row_q, row_d;
  logic [Aw-1:0]                  lin_q, lin_d;
  logic [Cw-1:0]                  cnt_q;
  logic                           rd_oor_q;
  logic                           out_valid_q;
  logic [ttpc_pkg::CellWidth-1:0] res_cell_q, out_cell_q;
  logic [ttpc_pkg::AddrWidth-1:0] res_pos_q, out_pos_q;
  logic                           res_scr_q, out_scr_q;

  logic                           in_fire;
  logic                           is_put, is_nl, wrap, row_adv, scroll;
  logic [Clw:0]                   col_next;
  logic [Aw:0]                    lin_next;
  logic [Rw:0]                    row_next;
  logic [Cw:0]                    rd_ptr;
  logic                           out_free;
  logic                           emit_load;
  logic                           scroll_copy;

  logic                           ram_we;
  logic [Aw-1:0]                  ram_waddr, ram_raddr;
  logic [ttpc_pkg::CellWidth-1:0] ram_wdata, ram_rdata;

  assign in_i.ready  = (state_q == StIdle);
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_free    = !out_valid_q || out_o.ready;
  assign emit_load   = (state_q == StEmit) && out_free;
  assign scroll_copy = (state_q == StScroll) && (cnt_q < Cw'(CopyCount));

  // Attribute register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ttpc_pkg::AttrReset;
    end else if (cfg_we_i) begin
      attr_q <= cfg_wdata_i;
    end
  end

  // Next cursor for a put
  always_comb begin
    is_put   = (in_i.action == ttpc_pkg::ActPut);
    is_nl    = (in_i.char_code == ttpc_pkg::NewlineCode);
    col_next = is_nl ? '0 : ({1'b0, col_q} + (Clw+1)'(1));
    lin_next = is_nl ? ({1'b0, lin_q} - (Aw+1)'(col_q) + (Aw+1)'(COLUMNS))
                     : ({1'b0, lin_q} + (Aw+1)'(1));
    wrap     = (col_next == (Clw+1)'(COLUMNS));
    row_adv  = is_nl || wrap;
    row_next = {1'b0, row_q} + (Rw+1)'(row_adv);
    scroll   = row_adv && (row_q == Rw'(ROWS - 1));
    col_d    = wrap ? '0 : col_next[Clw-1:0];
    row_d    = scroll ? Rw'(ROWS - 1) : row_next[Rw-1:0];
    lin_d    = scroll ? Aw'(CopyCount) : lin_next[Aw-1:0];
  end

  // RAM port control
  always_comb begin
    rd_ptr    = {1'b0, cnt_q} + (Cw+1)'(COLUMNS);
    ram_we    = 1'b0;
    ram_waddr = lin_q;
    ram_wdata = {attr_q, in_i.char_code};
    ram_raddr = Aw'(in_i.cell_address);
    unique case (state_q)
      StClear: begin
        ram_we    = 1'b1;
        ram_waddr = Aw'(cnt_q);
        ram_wdata = ttpc_pkg::BlankCell;
      end
      StIdle: begin
        ram_we = in_fire && is_put && !is_nl;
      end
      StScroll: begin
        // read runs one cell ahead of the write, COLUMNS cells further on
        if (rd_ptr < (Cw+1)'(CellCount)) begin
          ram_raddr = Aw'(rd_ptr);
        end
        ram_we    = (cnt_q != '0);
        ram_waddr = Aw'(cnt_q - Cw'(1));
        ram_wdata = (cnt_q <= Cw'(CopyCount)) ? ram_rdata : ttpc_pkg::BlankCell;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  ttpc_ram #(
    .Width (ttpc_pkg::CellWidth),
    .Depth (CellCount)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequencer, cursor and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      cnt_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
      lin_q       <= '0;
      rd_oor_q    <= 1'b0;
      res_cell_q  <= '0;
      res_pos_q   <= '0;
      res_scr_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_cell_q  <= '0;
      out_pos_q   <= '0;
      out_scr_q   <= 1'b0;
    end else begin
      if (out_o.ready && !emit_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StClear: begin
          cnt_q <= cnt_q + Cw'(1);
          if (cnt_q == Cw'(CellCount - 1)) begin
            state_q <= StIdle;
          end
        end
        StIdle: begin
          if (in_fire) begin
            if (is_put) begin
              col_q      <= col_d;
              row_q      <= row_d;
              lin_q      <= lin_d;
              res_cell_q <= '0;
              res_pos_q  <= ttpc_pkg::AddrWidth'(lin_d);
              res_scr_q  <= scroll;
              cnt_q      <= '0;
              state_q    <= scroll ? StScroll : StEmit;
            end else begin
              res_pos_q <= ttpc_pkg::AddrWidth'(lin_q);
              res_scr_q <= 1'b0;
              rd_oor_q  <= (32'(in_i.cell_address) >= 32'(CellCount));
              state_q   <= StReadWait;
            end
          end
        end
        StReadWait: begin
          res_cell_q <= rd_oor_q ? '0 : ram_rdata;
          state_q    <= StEmit;
        end
        StScroll: begin
          cnt_q <= cnt_q + Cw'(1);
          if (cnt_q == Cw'(CellCount)) begin
            state_q <= StEmit;
          end
        end
        StEmit: begin
          if (emit_load) begin
            out_valid_q <= 1'b1;
            out_cell_q  <= res_cell_q;
            out_pos_q   <= res_pos_q;
            out_scr_q   <= res_scr_q;
            state_q     <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.cell_value      = out_cell_q;
  assign out_o.cursor_position = out_pos_q;
  assign out_o.scrolled        = out_scr_q;

  // Checks
  `TTPC_ASSERT(a_cursor_in_range, (int'(col_q) < COLUMNS) && (int'(row_q) < ROWS), "bad cursor")
  `TTPC_ASSERT(a_lin_in_range, (32'(lin_q) < 32'(CellCount)), "linear cursor out of range")
  `TTPC_ASSERT(a_scroll_no_collide, scroll_copy |-> (ram_waddr != ram_raddr), "scroll overlap")
  `TTPC_ASSERT_NEXT(a_emit_loads, emit_load, out_valid_q && state_q == StIdle, "no result")

endmodule

>>> rtl/ttpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ttpc_ram #(
  parameter int Width = 16,
  parameter int Depth = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
